/* rtl/core/tcss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcss_pkg;

   // Width of the local and master time base.
   localparam int TIME_BITS = 32;
   localparam int DIV_IDX_W = $clog2(TIME_BITS);

   localparam int ADDR_W = 5;
   localparam int REG_IDX_W = 3;

   // Frame length and slot positions fit in 24 bits (255 * 65535).
   localparam int FRAME_W = 24;

   typedef enum logic [1:0] {
      MODE_TX_ACK   = 2'd0,
      MODE_ACK_RECV = 2'd1,
      MODE_QUERY    = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ACT_NONE      = 2'd0,
      ACT_SYNC_REQ  = 2'd1,
      ACT_SEND_DATA = 2'd2
   } action_type;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_NODE_SLOT_INDEX = 3'd0,
      REG_NODE_COUNT      = 3'd1,
      REG_SLOT_LENGTH     = 3'd2,
      REG_FILTER_SHIFT    = 3'd3,
      REG_MIN_ROUND_TRIP  = 3'd4
   } reg_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_FILT,
      S_DIV,
      S_DONE
   } state_type;

   localparam logic [7:0]  RST_NODE_SLOT_INDEX = 8'd3;
   localparam logic [7:0]  RST_NODE_COUNT      = 8'd30;
   localparam logic [15:0] RST_SLOT_LENGTH     = 16'd3000;
   localparam logic [2:0]  RST_FILTER_SHIFT    = 3'd2;
   localparam logic [15:0] RST_MIN_ROUND_TRIP  = 16'd150;

   localparam int MIN_PAYLOAD = 4;

endpackage

`default_nettype wire

/* rtl/core/tdma_clock_sync_slot_timer_top.sv */
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_ready   req_mode, req_start_stamp, req_local_stamp,
//                                              req_master_stamp, req_payload_length
// rsp       out        rsp_valid / rsp_ready   rsp_locked, rsp_offset_us, rsp_round_trip_us,
//                                              rsp_action, rsp_wait_us
// csr       in/out     psel, penable, pready   paddr, pwrite, pwdata, prdata
//
// A transmit acknowledgement, a short acknowledgement or an unused mode passes through the
// prepare and final steps; a received stamp also passes through the filter step.
// After lock, a schedule query finds the frame position with a restoring divider that
// handles one bit of the time per cycle.
// Reset is synchronous and active high; it restores the register defaults and clears lock.
// A new item is taken whenever the sequencer is idle, even while a result waits in the
// output register; the sequencer holds in its last step only if that register is still full.
`timescale 1ns / 1ps
`default_nettype none

module tdma_clock_sync_slot_timer_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [31:0]                       req_start_stamp,
   input  wire logic [31:0]                       req_local_stamp,
   input  wire logic [31:0]                       req_master_stamp,
   input  wire logic [5:0]                        req_payload_length,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_locked,
   output logic signed [31:0]                     rsp_offset_us,
   output logic [15:0]                            rsp_round_trip_us,
   output logic [1:0]                             rsp_action,
   output logic [23:0]                            rsp_wait_us,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tcss_pkg::ADDR_W-1:0]       paddr,
   input  wire logic [31:0]                       pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);

   localparam int TB = tcss_pkg::TIME_BITS;
   localparam int FW = tcss_pkg::FRAME_W;
   localparam int IW = tcss_pkg::DIV_IDX_W;

   tcss_pkg::state_type state_ff, state_in;

   logic [7:0]  slot_index_ff, slot_index_in;
   logic [7:0]  node_count_ff, node_count_in;
   logic [15:0] slot_len_ff, slot_len_in;
   logic [2:0]  filter_shift_ff, filter_shift_in;
   logic [15:0] min_rtt_ff, min_rtt_in;

   logic               locked_ff, locked_in;
   logic signed [31:0] offset_ff, offset_in;
   logic [15:0]        round_trip_ff, round_trip_in;

   tcss_pkg::mode_type mode_ff, mode_in;
   logic [31:0] start_ff, start_in;
   logic [31:0] local_ff, local_in;
   logic [31:0] master_ff, master_in;
   logic [5:0]  plen_ff, plen_in;

   logic signed [31:0] raw_ff, raw_in;
   logic [TB-1:0]      now_ff, now_in;
   logic [FW-1:0]      frame_ff, frame_in;
   logic [FW-1:0]      sstart_ff, sstart_in;
   logic [FW-1:0]      rem_ff, rem_in;
   logic [IW-1:0]      idx_ff, idx_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_locked_ff, rsp_locked_in;
   logic [31:0] rsp_offset_ff, rsp_offset_in;
   logic [15:0] rsp_rtt_ff, rsp_rtt_in;
   logic [1:0]  rsp_action_ff, rsp_action_in;
   logic [23:0] rsp_wait_ff, rsp_wait_in;

   logic                          cfg_write;
   logic [tcss_pkg::REG_IDX_W-1:0] cfg_idx;
   logic [7:0]                    cnt_eff;
   logic [15:0]                   slen_eff;
   logic [63:0]                   now_sum;
   logic [15:0]                   rtt_meas;
   logic [FW:0]                   rem_shift;
   logic [FW:0]                   send_pos;
   logic [FW:0]                   wrap_wait;
   logic [FW-1:0]                 wait_val;
   logic                          out_free;

   assign pready    = 1'b1;
   assign cfg_idx   = paddr[tcss_pkg::ADDR_W-1:2];
   assign cfg_write = psel && penable && pwrite && pready;

   assign req_ready = (state_ff == tcss_pkg::S_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_locked        = rsp_locked_ff;
   assign rsp_offset_us     = rsp_offset_ff;
   assign rsp_round_trip_us = rsp_rtt_ff;
   assign rsp_action        = rsp_action_ff;
   assign rsp_wait_us       = rsp_wait_ff;

   always_comb begin
      case (tcss_pkg::reg_index_type'(cfg_idx))
         tcss_pkg::REG_NODE_SLOT_INDEX: prdata = {24'd0, slot_index_ff};
         tcss_pkg::REG_NODE_COUNT:      prdata = {24'd0, node_count_ff};
         tcss_pkg::REG_SLOT_LENGTH:     prdata = {16'd0, slot_len_ff};
         tcss_pkg::REG_FILTER_SHIFT:    prdata = {29'd0, filter_shift_ff};
         tcss_pkg::REG_MIN_ROUND_TRIP:  prdata = {16'd0, min_rtt_ff};
         default:                       prdata = 32'd0;
      endcase
   end

   // Datapath terms used by the sequencer steps.
   assign cnt_eff   = (node_count_ff == 8'd0) ? 8'd1 : node_count_ff;
   assign slen_eff  = (slot_len_ff == 16'd0) ? 16'd1 : slot_len_ff;
   assign now_sum   = {32'd0, local_ff} + {{32{offset_ff[31]}}, offset_ff};
   assign rtt_meas  = local_ff[15:0] - start_ff[15:0];
   assign rem_shift = {rem_ff, now_ff[idx_ff]};
   assign send_pos  = {1'b0, sstart_ff} + {{(FW-15){1'b0}}, slen_eff};
   assign wrap_wait = {1'b0, frame_ff} - {1'b0, rem_ff} + {1'b0, sstart_ff};

   always_comb begin
      if (rem_ff < sstart_ff) begin
         wait_val = sstart_ff - rem_ff;
      end else if ({1'b0, rem_ff} < send_pos) begin
         wait_val = '0;
      end else begin
         wait_val = wrap_wait[FW-1:0];
      end
   end

   always_comb begin
      state_in        = state_ff;
      slot_index_in   = slot_index_ff;
      node_count_in   = node_count_ff;
      slot_len_in     = slot_len_ff;
      filter_shift_in = filter_shift_ff;
      min_rtt_in      = min_rtt_ff;
      locked_in       = locked_ff;
      offset_in       = offset_ff;
      round_trip_in   = round_trip_ff;
      mode_in         = mode_ff;
      start_in        = start_ff;
      local_in        = local_ff;
      master_in       = master_ff;
      plen_in         = plen_ff;
      raw_in          = raw_ff;
      now_in          = now_ff;
      frame_in        = frame_ff;
      sstart_in       = sstart_ff;
      rem_in          = rem_ff;
      idx_in          = idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_locked_in   = rsp_locked_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_rtt_in      = rsp_rtt_ff;
      rsp_action_in   = rsp_action_ff;
      rsp_wait_in     = rsp_wait_ff;

      if (cfg_write) begin
         case (tcss_pkg::reg_index_type'(cfg_idx))
            tcss_pkg::REG_NODE_SLOT_INDEX: slot_index_in   = pwdata[7:0];
            tcss_pkg::REG_NODE_COUNT:      node_count_in   = pwdata[7:0];
            tcss_pkg::REG_SLOT_LENGTH:     slot_len_in     = pwdata[15:0];
            tcss_pkg::REG_FILTER_SHIFT:    filter_shift_in = pwdata[2:0];
            tcss_pkg::REG_MIN_ROUND_TRIP:  min_rtt_in      = pwdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         tcss_pkg::S_IDLE: begin
            if (req_valid) begin
               mode_in   = tcss_pkg::mode_type'(req_mode);
               start_in  = req_start_stamp;
               local_in  = req_local_stamp;
               master_in = req_master_stamp;
               plen_in   = req_payload_length;
               state_in  = tcss_pkg::S_PREP;
            end
         end
         tcss_pkg::S_PREP: begin
            state_in = tcss_pkg::S_DONE;
            case (mode_ff)
               tcss_pkg::MODE_TX_ACK: begin
                  if (rtt_meas >= min_rtt_ff) begin
                     round_trip_in = rtt_meas;
                  end
               end
               tcss_pkg::MODE_ACK_RECV: begin
                  raw_in = master_ff + {17'd0, round_trip_ff[15:1]} - local_ff;
                  if (plen_ff >= 6'(tcss_pkg::MIN_PAYLOAD)) begin
                     state_in = tcss_pkg::S_FILT;
                  end
               end
               tcss_pkg::MODE_QUERY: begin
                  if (locked_ff) begin
                     frame_in  = {{(FW-8){1'b0}}, cnt_eff} * {{(FW-16){1'b0}}, slen_eff};
                     sstart_in = {{(FW-8){1'b0}}, slot_index_ff} *
                                 {{(FW-16){1'b0}}, slen_eff};
                     now_in    = now_sum[TB-1:0];
                     rem_in    = '0;
                     idx_in    = IW'(TB - 1);
                     state_in  = tcss_pkg::S_DIV;
                  end
               end
               default: ;
            endcase
         end
         tcss_pkg::S_FILT: begin
            if (!locked_ff) begin
               offset_in = raw_ff;
               locked_in = 1'b1;
            end else begin
               offset_in = offset_ff - (offset_ff >>> filter_shift_ff)
                           + (raw_ff >>> filter_shift_ff);
            end
            state_in = tcss_pkg::S_DONE;
         end
         tcss_pkg::S_DIV: begin
            // One remainder step per cycle, most significant time bit first.
            if (rem_shift >= {1'b0, frame_ff}) begin
               rem_in = FW'(rem_shift - {1'b0, frame_ff});
            end else begin
               rem_in = rem_shift[FW-1:0];
            end
            idx_in = idx_ff - IW'(1);
            if (idx_ff == '0) begin
               state_in = tcss_pkg::S_DONE;
            end
         end
         tcss_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_locked_in = locked_ff;
               rsp_offset_in = offset_ff;
               rsp_rtt_in    = round_trip_ff;
               rsp_action_in = tcss_pkg::ACT_NONE;
               rsp_wait_in   = '0;
               if (mode_ff == tcss_pkg::MODE_QUERY) begin
                  if (locked_ff) begin
                     rsp_action_in = tcss_pkg::ACT_SEND_DATA;
                     rsp_wait_in   = wait_val;
                  end else begin
                     rsp_action_in = tcss_pkg::ACT_SYNC_REQ;
                  end
               end
               state_in = tcss_pkg::S_IDLE;
            end
         end
         default: state_in = tcss_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tcss_pkg::S_IDLE;
         slot_index_ff   <= tcss_pkg::RST_NODE_SLOT_INDEX;
         node_count_ff   <= tcss_pkg::RST_NODE_COUNT;
         slot_len_ff     <= tcss_pkg::RST_SLOT_LENGTH;
         filter_shift_ff <= tcss_pkg::RST_FILTER_SHIFT;
         min_rtt_ff      <= tcss_pkg::RST_MIN_ROUND_TRIP;
         locked_ff       <= 1'b0;
         offset_ff       <= '0;
         round_trip_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         slot_index_ff   <= slot_index_in;
         node_count_ff   <= node_count_in;
         slot_len_ff     <= slot_len_in;
         filter_shift_ff <= filter_shift_in;
         min_rtt_ff      <= min_rtt_in;
         locked_ff       <= locked_in;
         offset_ff       <= offset_in;
         round_trip_ff   <= round_trip_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      start_ff      <= start_in;
      local_ff      <= local_in;
      master_ff     <= master_in;
      plen_ff       <= plen_in;
      raw_ff        <= raw_in;
      now_ff        <= now_in;
      frame_ff      <= frame_in;
      sstart_ff     <= sstart_in;
      rem_ff        <= rem_in;
      idx_ff        <= idx_in;
      rsp_locked_ff <= rsp_locked_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_rtt_ff    <= rsp_rtt_in;
      rsp_action_ff <= rsp_action_in;
      rsp_wait_ff   <= rsp_wait_in;
   end

   // Once lock is taken it is only lost through reset.
   a_lock_sticky: assert property (@(posedge clock) disable iff (reset)
      locked_ff |=> locked_ff)
      else $error("lock dropped without reset");

   // The partial remainder always stays below the frame length.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcss_pkg::S_DIV) |-> (rem_ff < frame_ff))
      else $error("divider remainder out of range");

   // A result is only loaded from the final sequencer step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == tcss_pkg::S_DONE))
      else $error("result loaded outside the final step");

   // The stored round trip changes only while a transmit acknowledgement is processed.
   a_rtt_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (round_trip_ff != $past(round_trip_ff))) |->
      ($past(state_ff) == tcss_pkg::S_PREP && $past(mode_ff) == tcss_pkg::MODE_TX_ACK))
      else $error("round trip changed outside a transmit acknowledgement");

   // The offset changes only in the filter step.
   a_offset_source: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (offset_ff != $past(offset_ff))) |->
      ($past(state_ff) == tcss_pkg::S_FILT))
      else $error("offset changed outside the filter step");

endmodule

`default_nettype wire
